>>> rtl/psh_pkg.sv
// Shared constants, types and codes of the projectile step and hit test block.
`timescale 1ns / 1ps

package psh_pkg;

  // Block parameters
  localparam int ARENA_SIZE      = 720;
  localparam int BOX_WIDTH       = 6;
  localparam int BOX_HEIGHT      = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int HIT_RADIUS      = 5;
  localparam int ARENA_MARGIN    = 100;

  // Field widths
  localparam int POS_W  = 20;
  localparam int SPD_W  = 16;
  localparam int HEAD_W = 12;
  localparam int TIME_W = 32;
  localparam int LIFE_W = 32;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 3;

  // Shared multiply-accumulate unit
  localparam int OPA_W  = 22;
  localparam int OPB_W  = 16;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int FRAC   = 14;
  localparam int SH_W   = ACC_W - FRAC;

  // Stream widths
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [IDX_W-1:0] {
    CFG_START_X     = 3'd0,
    CFG_START_Y     = 3'd1,
    CFG_HEADING     = 3'd2,
    CFG_START_SPEED = 3'd3,
    CFG_ACCEL       = 3'd4,
    CFG_LIFETIME    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MAC_HOLD = 2'd0,
    MAC_LOAD = 2'd1,
    MAC_ADD  = 2'd2,
    MAC_SUB  = 2'd3
  } mac_op_e;

  typedef struct packed {
    mac_op_e                 op;
    logic signed [OPA_W-1:0] a;
    logic signed [OPB_W-1:0] b;
  } mac_ctrl_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  start_x;
    logic signed [POS_W-1:0]  start_y;
    logic [HEAD_W-1:0]        heading;
    logic signed [SPD_W-1:0]  start_speed;
    logic signed [SPD_W-1:0]  accel;
    logic signed [LIFE_W-1:0] lifetime;
  } cfg_t;

  typedef struct packed {
    logic                    tick;
    logic signed [POS_W-1:0] player_x;
    logic signed [POS_W-1:0] player_y;
    logic                    shielded;
    logic                    paused;
    logic [TIME_W-1:0]       now;
  } req_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    hit;
    logic                    off_arena;
    logic                    expired;
  } res_t;

endpackage

>>> rtl/projectile_step_and_hit_test.sv
// Top level of the projectile step and hit test: stream ports, registers, result buffer.
`timescale 1ns / 1ps
// Launch item (tuser 0): loads start position, speed and launch time, then goes to done.
// Tick item (tuser 1): runs the sine, motion, rotation and distance steps on the single
// shared multiply-accumulate unit, which runs 16 products in turn: sine and cosine (4 each),
// motion (2), rotation (4) and distance (2). A new item is taken only once the last result
// is in the result buffer. Reset (rst_ni low, asynchronous) zeroes position, speed, launch
// time, sets configuration registers to zero but lifetime to -1, and empties the result buffer.

module projectile_step_and_hit_test (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [psh_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [psh_pkg::CFG_W-1:0]         cfg_wdata_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata, low bit up: player_x[19:0], player_y[39:20], player_shielded[40], paused[41],
  // now[73:42], zero pad[79:74]
  input  logic [psh_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: mode[0] (0 launch, 1 tick)
  input  logic [psh_pkg::IN_USER_W-1:0]     s_axis_tuser,
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata, low bit up: pos_x[19:0], pos_y[39:20], hit[40], off_arena[41], expired[42],
  // zero pad[47:43]
  output logic [psh_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import psh_pkg::*;

  cfg_t                     cfg_q;
  req_t                     req;
  res_t                     res;
  mac_ctrl_t                mac_ctrl;
  logic signed [ACC_W-1:0]  acc;
  logic                     idle, done, out_free;
  logic                     m_valid_q;
  logic [OUT_DATA_W-1:0]    m_data_q;

  // Configuration registers: take a write on any edge with the enable high,
  // drop writes to indexes beyond the list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_x     <= '0;
      cfg_q.start_y     <= '0;
      cfg_q.heading     <= '0;
      cfg_q.start_speed <= '0;
      cfg_q.accel       <= '0;
      cfg_q.lifetime    <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_X:     cfg_q.start_x     <= cfg_wdata_i[POS_W-1:0];
        CFG_START_Y:     cfg_q.start_y     <= cfg_wdata_i[POS_W-1:0];
        CFG_HEADING:     cfg_q.heading     <= cfg_wdata_i[HEAD_W-1:0];
        CFG_START_SPEED: cfg_q.start_speed <= cfg_wdata_i[SPD_W-1:0];
        CFG_ACCEL:       cfg_q.accel       <= cfg_wdata_i[SPD_W-1:0];
        CFG_LIFETIME:    cfg_q.lifetime    <= cfg_wdata_i[LIFE_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input item.
  assign req.tick     = s_axis_tuser[0];
  assign req.player_x = s_axis_tdata[19:0];
  assign req.player_y = s_axis_tdata[39:20];
  assign req.shielded = s_axis_tdata[40];
  assign req.paused   = s_axis_tdata[41];
  assign req.now      = s_axis_tdata[73:42];

  // The sequencer only takes an item while idle; the result buffer lets it go
  // idle again as soon as its result is parked there.
  assign s_axis_tready = idle;
  assign out_free      = !m_valid_q || m_axis_tready;

  psh_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_i       (req),
    .req_valid_i (s_axis_tvalid),
    .out_free_i  (out_free),
    .idle_o      (idle),
    .done_o      (done),
    .res_o       (res),
    .mac_o       (mac_ctrl),
    .acc_i       (acc)
  );

  psh_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .acc_o  (acc)
  );

  // Result buffer: load when the sequencer finishes and the slot is free,
  // hold until the consumer takes the item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (done && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && out_free) begin
      m_data_q <= {5'b00000, res.expired, res.off_arena, res.hit, res.pos_y, res.pos_x};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> rtl/psh_mac.sv
// Shared signed multiply-accumulate unit of the projectile block.
`timescale 1ns / 1ps

module psh_mac (
  input  logic                              clk_i,
  input  psh_pkg::mac_ctrl_t                ctrl_i,
  output logic signed [psh_pkg::ACC_W-1:0]  acc_o
);
  import psh_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_d, acc_q;

  assign prod = PROD_W'(ctrl_i.a) * PROD_W'(ctrl_i.b);

  always_comb begin
    case (ctrl_i.op)
      MAC_LOAD: acc_d = ACC_W'(prod);
      MAC_ADD:  acc_d = acc_q + ACC_W'(prod);
      MAC_SUB:  acc_d = acc_q - ACC_W'(prod);
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

>>> rtl/psh_seq.sv
// Sequencer and datapath registers: sine, motion, rotation and distance steps.
`timescale 1ns / 1ps

module psh_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  psh_pkg::cfg_t                    cfg_i,
  input  psh_pkg::req_t                    req_i,
  input  logic                             req_valid_i,
  input  logic                             out_free_i,
  output logic                             idle_o,
  output logic                             done_o,
  output psh_pkg::res_t                    res_o,
  output psh_pkg::mac_ctrl_t               mac_o,
  input  logic signed [psh_pkg::ACC_W-1:0] acc_i
);
  import psh_pkg::*;

  localparam int PS_W = SH_W + 1;
  localparam int E_W  = 12;
  localparam logic signed [PS_W-1:0]  P_MAX  = PS_W'(2 ** (POS_W - 1) - 1);
  localparam logic signed [PS_W-1:0]  P_MIN  = PS_W'(-(2 ** (POS_W - 1)));
  localparam logic signed [SPD_W:0]   S_MAX  = (SPD_W + 1)'(2 ** (SPD_W - 1) - 1);
  localparam logic signed [SPD_W:0]   S_MIN  = (SPD_W + 1)'(-(2 ** (SPD_W - 1)));
  localparam logic signed [SH_W-1:0]  HALF_W = SH_W'(BOX_WIDTH * 128);
  localparam logic signed [SH_W-1:0]  HALF_H = SH_W'(BOX_HEIGHT * 128);
  localparam logic signed [SH_W-1:0]  E_LIM  = SH_W'(2 ** (E_W - 1) - 1);
  localparam logic signed [POS_W-1:0] OFF_HI = POS_W'((ARENA_SIZE + ARENA_MARGIN) * 256);
  localparam logic signed [POS_W-1:0] OFF_LO = POS_W'(-(ARENA_MARGIN * 256));
  localparam logic signed [ACC_W-1:0] HIT_R2 =
    ACC_W'((HIT_RADIUS * 256) * (HIT_RADIUS * 256));
  localparam logic [HEAD_W-1:0] ANG_MASK = HEAD_W'({HEAD_W{1'b1}} << (HEAD_W - SINE_TABLE_BITS));
  localparam logic [HEAD_W-1:0] QUARTER  = HEAD_W'(2 ** (HEAD_W - 2));
  localparam logic [15:0] SIN_C1 = 16'd1160;
  localparam logic [15:0] SIN_C2 = 16'd10512;
  localparam logic [15:0] SIN_C3 = 16'd25736;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SINE = 6'b000010,
    ST_MOVE = 6'b000100,
    ST_ROT  = 6'b001000,
    ST_DIST = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e                  state_d, state_q;
  logic [1:0]              step_d, step_q;
  logic                    pass_d, pass_q;

  logic signed [POS_W-1:0] cur_x_q, cur_y_q;
  logic signed [SPD_W-1:0] cur_speed_q;
  logic [TIME_W-1:0]       launch_q;

  req_t                    req_q;
  logic [HEAD_W-1:0]       ang_q;
  logic [15:0]             z2_q;
  logic                    sneg_q;
  logic signed [OPB_W-1:0] sin_q, cos_q;
  logic signed [SH_W-1:0]  rx_q;
  logic signed [E_W-1:0]   ey_q;

  logic [HEAD_W-1:0]       ang_cur;
  logic [10:0]             zq;
  logic [14:0]             zbig;
  logic signed [SH_W-1:0]  sh;
  logic [15:0]             sh16;
  logic signed [OPB_W-1:0] sval;
  logic signed [SPD_W:0]   spd_sum;
  logic signed [SPD_W-1:0] spd_new;
  logic signed [OPA_W-1:0] dx, dy;
  logic signed [E_W-1:0]   ex, ey;
  logic signed [PS_W-1:0]  x_sum, y_sum;
  logic [TIME_W-1:0]       age;
  logic                    accept;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PS_W-1:0] v);
    if (v > P_MAX) return P_MAX[POS_W-1:0];
    if (v < P_MIN) return P_MIN[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

  // Distance outside the box along one axis, clipped: beyond the clip a hit is impossible.
  function automatic logic signed [E_W-1:0] excess(input logic signed [SH_W-1:0] v,
                                                   input logic signed [SH_W-1:0] h);
    logic signed [SH_W-1:0] e;
    if (v > h) e = v - h;
    else if (v < -h) e = v + h;
    else e = '0;
    if (e > E_LIM) e = E_LIM;
    else if (e < -E_LIM) e = -E_LIM;
    return e[E_W-1:0];
  endfunction

  assign accept  = (state_q == ST_IDLE) && req_valid_i;
  assign ang_cur = ang_q + (pass_q ? QUARTER : '0);
  assign zq      = ang_cur[10] ? 11'd1024 - {1'b0, ang_cur[9:0]} : {1'b0, ang_cur[9:0]};
  assign zbig    = {zq, 4'b0000};
  assign sh      = SH_W'(acc_i >>> FRAC);
  assign sh16    = sh[15:0];
  assign sval    = sneg_q ? -$signed(sh16) : $signed(sh16);

  assign spd_sum = (SPD_W + 1)'(cur_speed_q) + (SPD_W + 1)'(cfg_i.accel);
  assign spd_new = (spd_sum > S_MAX) ? S_MAX[SPD_W-1:0] :
                   (spd_sum < S_MIN) ? S_MIN[SPD_W-1:0] : spd_sum[SPD_W-1:0];

  assign dx = OPA_W'(req_q.player_x) - OPA_W'(cur_x_q) - OPA_W'(HALF_W);
  assign dy = OPA_W'(req_q.player_y) - OPA_W'(cur_y_q) - OPA_W'(HALF_H);
  assign ex = excess(rx_q, HALF_W);
  assign ey = excess(sh, HALF_H);

  assign x_sum = PS_W'(cur_x_q) + PS_W'(sh);
  assign y_sum = PS_W'(cur_y_q) - PS_W'(sh);

  // Sequence
  always_comb begin
    state_d = state_q;
    step_d  = step_q + 2'd1;
    pass_d  = pass_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        pass_d = 1'b0;
        if (req_valid_i) state_d = req_i.tick ? ST_SINE : ST_DONE;
      end
      ST_SINE: begin
        if (step_q == 2'd3) begin
          pass_d = 1'b1;
          if (pass_q) state_d = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (step_q == 2'd1) begin
          state_d = ST_ROT;
          step_d  = '0;
        end
      end
      ST_ROT: begin
        if (step_q == 2'd3) state_d = ST_DIST;
      end
      ST_DIST: begin
        if (step_q == 2'd1) state_d = ST_DONE;
      end
      ST_DONE: begin
        step_d = '0;
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Operand selection for the shared unit
  always_comb begin
    mac_o.op = MAC_HOLD;
    mac_o.a  = '0;
    mac_o.b  = '0;
    unique case (state_q)
      ST_SINE: begin
        mac_o.op = MAC_LOAD;
        case (step_q)
          2'd0: begin
            mac_o.a = OPA_W'(zbig);
            mac_o.b = $signed({1'b0, zbig});
          end
          2'd1: begin
            mac_o.a = OPA_W'(sh16);
            mac_o.b = $signed(SIN_C1);
          end
          2'd2: begin
            mac_o.a = OPA_W'(z2_q);
            mac_o.b = $signed(SIN_C2 - sh16);
          end
          default: begin
            mac_o.a = OPA_W'(zbig);
            mac_o.b = $signed(SIN_C3 - sh16);
          end
        endcase
      end
      ST_MOVE: begin
        mac_o.op = MAC_LOAD;
        if (step_q == 2'd0) begin
          mac_o.a = OPA_W'(spd_new);
          mac_o.b = sin_q;
        end else begin
          mac_o.a = OPA_W'(cur_speed_q);
          mac_o.b = cos_q;
        end
      end
      ST_ROT: begin
        case (step_q)
          2'd0: begin
            mac_o.op = MAC_LOAD;
            mac_o.a  = dx;
            mac_o.b  = cos_q;
          end
          2'd1: begin
            mac_o.op = MAC_ADD;
            mac_o.a  = dy;
            mac_o.b  = sin_q;
          end
          2'd2: begin
            mac_o.op = MAC_LOAD;
            mac_o.a  = dy;
            mac_o.b  = cos_q;
          end
          default: begin
            mac_o.op = MAC_SUB;
            mac_o.a  = dx;
            mac_o.b  = sin_q;
          end
        endcase
      end
      ST_DIST: begin
        if (step_q == 2'd0) begin
          mac_o.op = MAC_LOAD;
          mac_o.a  = OPA_W'(ex);
          mac_o.b  = OPB_W'(ex);
        end else begin
          mac_o.op = MAC_ADD;
          mac_o.a  = OPA_W'(ey_q);
          mac_o.b  = OPB_W'(ey_q);
        end
      end
      default: ;
    endcase
  end

  // Control and projectile state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      pass_q      <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cur_speed_q <= '0;
      launch_q    <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pass_q  <= pass_d;
      if (accept && !req_i.tick) begin
        cur_x_q     <= cfg_i.start_x;
        cur_y_q     <= cfg_i.start_y;
        cur_speed_q <= cfg_i.start_speed;
        launch_q    <= req_i.now;
      end
      if (!req_q.paused) begin
        if (state_q == ST_MOVE && step_q == 2'd0) cur_speed_q <= spd_new;
        if (state_q == ST_MOVE && step_q == 2'd1) cur_x_q <= sat_pos(x_sum);
        if (state_q == ST_ROT && step_q == 2'd0) cur_y_q <= sat_pos(y_sum);
      end
    end
  end

  // Working values
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
      ang_q <= cfg_i.heading & ANG_MASK;
    end
    if (state_q == ST_SINE) begin
      if (step_q == 2'd0 && pass_q) sin_q <= sval;
      if (step_q == 2'd1) z2_q <= sh16;
      if (step_q == 2'd3) sneg_q <= ang_cur[11];
    end
    if (state_q == ST_MOVE && step_q == 2'd0) cos_q <= sval;
    if (state_q == ST_ROT && step_q == 2'd2) rx_q <= sh;
    if (state_q == ST_DIST && step_q == 2'd0) ey_q <= ey;
  end

  assign age = req_q.now - launch_q;

  assign idle_o          = (state_q == ST_IDLE);
  assign done_o          = (state_q == ST_DONE);
  assign res_o.pos_x     = cur_x_q;
  assign res_o.pos_y     = cur_y_q;
  assign res_o.hit       = req_q.tick && (acc_i <= HIT_R2) && !req_q.shielded && !req_q.paused;
  assign res_o.off_arena = (cur_x_q > OFF_HI) || (cur_x_q < OFF_LO) ||
                           (cur_y_q > OFF_HI) || (cur_y_q < OFF_LO);
  assign res_o.expired   = !cfg_i.lifetime[LIFE_W-1] && (age > $unsigned(cfg_i.lifetime));

`ifndef SYNTHESIS
  a_tick_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.tick) |-> ##17 (state_q == ST_DONE))
    else $error("tick item did not reach done after its fixed step count");

  a_paused_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.tick && req_i.paused) |-> ##17
      ((cur_x_q == $past(cur_x_q, 17)) && (cur_y_q == $past(cur_y_q, 17)) &&
       (cur_speed_q == $past(cur_speed_q, 17))))
    else $error("paused tick moved the projectile");

  a_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !req_i.tick) |=>
      ((state_q == ST_DONE) && (cur_x_q == $past(cfg_i.start_x)) && !res_o.hit))
    else $error("launch item did not load the start position");

  a_acc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !out_free_i) |=> $stable(acc_i))
    else $error("accumulator changed while the result waits");
`endif

endmodule
